### rtl/axis_angle_vector_rotation_unit_defines.svh
// Assertion macros shared by the rotation unit RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef AXIS_ANGLE_VECTOR_ROTATION_UNIT_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AVR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rotation unit check failed");

// Next-cycle implication, checked outside reset.
`define AVR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rotation unit check failed");

`endif

### rtl/avr_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the rotation unit.
// No dependencies.
`default_nettype none
package avr_pkg;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_in_t;

	typedef struct packed {
		logic signed [31:0] rotated_x;
		logic signed [31:0] rotated_y;
		logic signed [31:0] rotated_z;
	} point_out_t;

	typedef enum logic [1:0] {
		REG_AXIS_X = 2'd0,
		REG_AXIS_Y = 2'd1,
		REG_AXIS_Z = 2'd2,
		REG_ANGLE  = 2'd3
	} reg_idx_t;

	// Matrix entries are Q2.16, row major.
	typedef logic [8:0][17:0] matrix_t;

	typedef struct packed {
		logic    busy;
		matrix_t mat;
	} mgen_status_t;

	localparam int ATAN_ENTRIES = 24;
	localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;

	// Arctangent of 2^-i in units of 2^32 per turn.
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/axis_angle_vector_rotation_unit.sv
// Top level of the axis-angle rotation unit: matrix generator plus point pipeline.
// Depends on avr_pkg, avr_matrix_gen, avr_point_pipe and the defines header.
`default_nettype none
`include "axis_angle_vector_rotation_unit_defines.svh"

// Rotates each Q16.16 point word about a unit Q2.14 axis by a binary angle.
// Points stream at one word per cycle while no output word is held and the
// matrix is settled; each word passes the input, multiply, sum and saturate
// registers on its way to a valid result. After reset and after every
// register write the matrix is rebuilt by an iterative CORDIC (one step per
// cycle) and a sequencer with a product and an accumulate state per entry;
// in_ready stays low during the rebuild; register writes are taken as ever.
module axis_angle_vector_rotation_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_addr,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire avr_pkg::point_in_t in_point,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output avr_pkg::point_out_t     out_point
);

	avr_pkg::mgen_status_t status;
	logic                  advance;

	// Rebuilds the matrix whenever the configuration changes.
	avr_matrix_gen #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_mgen (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.status   (status)
	);

	// Input words enter only when the matrix is settled and the pipe moves.
	assign in_ready = advance && !status.busy;

	avr_point_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (in_valid && in_ready),
		.in_point (in_point),
		.mat      (status.mat),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_point(out_point),
		.advance  (advance)
	);

	`AVR_ASSERT_NOW(a_busy_blocks_input, status.busy, !in_ready)
	`AVR_ASSERT_NEXT(a_write_starts_rebuild, cfg_we, status.busy)
	`AVR_ASSERT_NOW(a_held_word_stalls_input, out_valid && !out_ready, !in_ready)

endmodule
`default_nettype wire

### rtl/avr_matrix_gen.sv
// Configuration registers and the sequencer that derives cos/sin by CORDIC
// and builds the Rodrigues matrix one entry at a time. Depends on avr_pkg.
`default_nettype none
module avr_matrix_gen #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_addr,
	input  wire logic [15:0]          cfg_wdata,
	output avr_pkg::mgen_status_t     status
);

	localparam int STEPS_EFF = (CORDIC_STEPS > avr_pkg::ATAN_ENTRIES) ?
		avr_pkg::ATAN_ENTRIES : CORDIC_STEPS;
	localparam logic [4:0] LAST_STEP = 5'(STEPS_EFF - 1);

	typedef enum logic [2:0] {
		ST_LOAD, ST_ROT, ST_FIN, ST_PROD, ST_ACC, ST_IDLE
	} state_t;

	typedef enum logic [1:0] {LIN_DIAG, LIN_POS, LIN_NEG} lin_kind_t;

	state_t             state_q;
	logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;
	logic        [15:0] angle_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic        [4:0]  step_q;
	logic signed [19:0] cos_q, sin_q, t_q;
	logic        [3:0]  ent_q;
	logic signed [31:0] quad_q;
	logic signed [55:0] lin_q;
	avr_pkg::matrix_t   mat_q;

	// Entry decode: row and column axes, third axis and linear term kind.
	logic [1:0]  sel_r, sel_c, sel_m;
	lin_kind_t   lin_kind;
	always_comb begin
		sel_r = 2'd0; sel_c = 2'd0; sel_m = 2'd0; lin_kind = LIN_DIAG;
		unique case (ent_q)
			4'd0: begin sel_r = 2'd0; sel_c = 2'd0; sel_m = 2'd0; lin_kind = LIN_DIAG; end
			4'd1: begin sel_r = 2'd0; sel_c = 2'd1; sel_m = 2'd2; lin_kind = LIN_NEG; end
			4'd2: begin sel_r = 2'd0; sel_c = 2'd2; sel_m = 2'd1; lin_kind = LIN_POS; end
			4'd3: begin sel_r = 2'd1; sel_c = 2'd0; sel_m = 2'd2; lin_kind = LIN_POS; end
			4'd4: begin sel_r = 2'd1; sel_c = 2'd1; sel_m = 2'd0; lin_kind = LIN_DIAG; end
			4'd5: begin sel_r = 2'd1; sel_c = 2'd2; sel_m = 2'd0; lin_kind = LIN_NEG; end
			4'd6: begin sel_r = 2'd2; sel_c = 2'd0; sel_m = 2'd1; lin_kind = LIN_NEG; end
			4'd7: begin sel_r = 2'd2; sel_c = 2'd1; sel_m = 2'd0; lin_kind = LIN_POS; end
			4'd8: begin sel_r = 2'd2; sel_c = 2'd2; sel_m = 2'd0; lin_kind = LIN_DIAG; end
			default: begin sel_r = 2'd0; sel_c = 2'd0; sel_m = 2'd0; lin_kind = LIN_DIAG; end
		endcase
	end

	function automatic logic signed [15:0] pick_axis(input logic [1:0] idx,
		input logic signed [15:0] ax, input logic signed [15:0] ay,
		input logic signed [15:0] az);
		logic signed [15:0] r;
		unique case (idx)
			2'd0: r = ax;
			2'd1: r = ay;
			default: r = az;
		endcase
		return r;
	endfunction

	logic signed [15:0] ar, ac, am;
	assign ar = pick_axis(sel_r, axis_x_q, axis_y_q, axis_z_q);
	assign ac = pick_axis(sel_c, axis_x_q, axis_y_q, axis_z_q);
	assign am = pick_axis(sel_m, axis_x_q, axis_y_q, axis_z_q);

	// One CORDIC micro-rotation.
	logic signed [33:0] sh_x, sh_y, atan_v;
	assign sh_x   = cx_q >>> step_q;
	assign sh_y   = cy_q >>> step_q;
	assign atan_v = $signed({2'b00, avr_pkg::atan_turn(step_q)});

	// Final rounding of cos and sin to Q2.16.
	logic signed [33:0] xr_full, yr_full;
	logic signed [19:0] xr, yr;
	assign xr_full = (cx_q + 34'sd8192) >>> 14;
	assign yr_full = (cy_q + 34'sd8192) >>> 14;
	assign xr      = xr_full[19:0];
	assign yr      = yr_full[19:0];

	// Linear term and quadratic product for the current entry.
	logic signed [35:0] ms_prod;
	logic signed [55:0] lin_next;
	assign ms_prod = am * sin_q;
	always_comb begin
		unique case (lin_kind)
			LIN_DIAG: lin_next = 56'(cos_q) <<< 28;
			LIN_POS:  lin_next = 56'(ms_prod) <<< 14;
			LIN_NEG:  lin_next = -(56'(ms_prod) <<< 14);
			default:  lin_next = '0;
		endcase
	end

	// Entry sum, rounding and saturation.
	logic signed [51:0] qt_prod;
	logic signed [55:0] ent_sum, ent_rnd;
	logic signed [17:0] ent_sat;
	assign qt_prod = quad_q * t_q;
	assign ent_sum = 56'(qt_prod) + lin_q;
	assign ent_rnd = (ent_sum + 56'sd134217728) >>> 28;
	always_comb begin
		if (ent_rnd > 56'sd131071)
			ent_sat = 18'sd131071;
		else if (ent_rnd < -56'sd131072)
			ent_sat = -18'sd131072;
		else
			ent_sat = ent_rnd[17:0];
	end

	// Sequencer with configuration registers and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			axis_x_q <= 16'sd0;
			axis_y_q <= 16'sd0;
			axis_z_q <= 16'sd16384;
			angle_q  <= 16'd0;
			cx_q     <= '0;
			cy_q     <= '0;
			cz_q     <= '0;
			flip_q   <= 1'b0;
			step_q   <= '0;
			cos_q    <= '0;
			sin_q    <= '0;
			t_q      <= '0;
			ent_q    <= '0;
			quad_q   <= '0;
			lin_q    <= '0;
			mat_q    <= '0;
		end else if (cfg_we) begin
			unique case (avr_pkg::reg_idx_t'(cfg_addr))
				avr_pkg::REG_AXIS_X: axis_x_q <= cfg_wdata;
				avr_pkg::REG_AXIS_Y: axis_y_q <= cfg_wdata;
				avr_pkg::REG_AXIS_Z: axis_z_q <= cfg_wdata;
				avr_pkg::REG_ANGLE:  angle_q  <= cfg_wdata;
				default: ;
			endcase
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					// Fold the middle half turn onto the other side.
					flip_q  <= angle_q[15] ^ angle_q[14];
					cz_q    <= 34'($signed({angle_q[15] ^ angle_q[15] ^ angle_q[14] ^
						angle_q[15] ^ angle_q[15], angle_q[14:0], 16'd0}));
					cx_q    <= $signed({2'b00, avr_pkg::CORDIC_X0});
					cy_q    <= '0;
					step_q  <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - sh_y;
						cy_q <= cy_q + sh_x;
						cz_q <= cz_q - atan_v;
					end else begin
						cx_q <= cx_q + sh_y;
						cy_q <= cy_q - sh_x;
						cz_q <= cz_q + atan_v;
					end
					step_q <= step_q + 5'd1;
					if (step_q == LAST_STEP)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					cos_q   <= flip_q ? -xr : xr;
					sin_q   <= flip_q ? -yr : yr;
					t_q     <= 20'sd65536 - (flip_q ? -xr : xr);
					ent_q   <= '0;
					state_q <= ST_PROD;
				end
				ST_PROD: begin
					quad_q  <= ar * ac;
					lin_q   <= lin_next;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					mat_q[ent_q] <= ent_sat;
					if (ent_q == 4'd8) begin
						state_q <= ST_IDLE;
					end else begin
						ent_q   <= ent_q + 4'd1;
						state_q <= ST_PROD;
					end
				end
				default: ;
			endcase
		end
	end

	assign status.busy = (state_q != ST_IDLE);
	assign status.mat  = mat_q;

endmodule
`default_nettype wire

### rtl/avr_point_pipe.sv
// Four-stage matrix-vector pipeline with rounding and saturation.
// Depends on avr_pkg.
`default_nettype none
module avr_point_pipe (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire avr_pkg::point_in_t  in_point,
	input  wire avr_pkg::matrix_t    mat,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output avr_pkg::point_out_t      out_point,
	output logic                     advance
);

	logic                       v_s1, v_s2, v_s3, v_s4;
	avr_pkg::point_in_t         p_s1;
	logic signed [8:0][49:0]    prod_s2;
	logic signed [2:0][35:0]    acc_s3;
	avr_pkg::point_out_t        res_s4;

	// The whole pipe moves together unless the output word is held.
	assign advance = !v_s4 || out_ready;

	logic signed [2:0][31:0] pv;
	assign pv[0] = p_s1.point_x;
	assign pv[1] = p_s1.point_y;
	assign pv[2] = p_s1.point_z;

	// Nine products of point and matrix entries.
	logic signed [8:0][49:0] prod_c;
	always_comb begin
		for (int k = 0; k < 9; k++)
			prod_c[k] = $signed(pv[k % 3]) * $signed(mat[k]);
	end

	// Row sums rounded back to Q16.16.
	logic signed [2:0][35:0] acc_c;
	always_comb begin
		logic signed [51:0] s;
		for (int r = 0; r < 3; r++) begin
			s = 52'($signed(prod_s2[3*r])) + 52'($signed(prod_s2[3*r+1])) +
				52'($signed(prod_s2[3*r+2])) + 52'sd32768;
			acc_c[r] = s[51:16];
		end
	end

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Data stages.
	always_ff @(posedge clk) begin
		if (advance) begin
			p_s1    <= in_point;
			prod_s2 <= prod_c;
			acc_s3  <= acc_c;
			res_s4.rotated_x <= sat32($signed(acc_s3[0]));
			res_s4.rotated_y <= sat32($signed(acc_s3[1]));
			res_s4.rotated_z <= sat32($signed(acc_s3[2]));
		end
	end

	assign out_valid = v_s4;
	assign out_point = res_s4;

endmodule
`default_nettype wire
